// File: rtl/key_tag_sorter_top_assert.svh
// Assertion macros for the checker of the sorter.
`ifndef KEY_TAG_SORTER_TOP_ASSERT_SVH
`define KEY_TAG_SORTER_TOP_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define KTS_ASSERT_HOLD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define KTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Types and constants shared by the key/tag sorter modules.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int KEY_W     = 32;
    localparam int TAG_W     = 16;
    localparam int MAX_ITEMS = 64;

    // One input word.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last;
    } item_t;

    // One result word.
    typedef struct packed {
        logic signed [KEY_W-1:0] key_res;
        logic [TAG_W-1:0]        tag_res;
        logic                    last_res;
        logic                    overflow;
    } res_t;

endpackage

// File: rtl/key_tag_sorter_top.sv
// ----------------------------------------------------------------------------
// key_tag_sorter_top
// Loads a set of key/tag pairs and emits them in stable ascending key order.
// ----------------------------------------------------------------------------
// Channel | Handshake              | Word
// item    | item_valid, item_stall | kts_pkg::item_t (key, tag, last)
// res     | res_valid, res_stall   | kts_pkg::res_t (key_res, tag_res, ...)
//
// A set loads one word per cycle into the key/tag memory.
// Each result is found by a selection pass over the memory read port: the
// pass reads every stored entry and keeps the smallest one that follows the
// previous result, then the emit state hands that selection off.
// Reset clears the control state only; the memory needs no clearing.
// A stalled result holds; no item is taken until the whole set is drained.
module key_tag_sorter_top #(
    parameter int MAX_ITEMS = kts_pkg::MAX_ITEMS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  kts_pkg::item_t item,
    output logic           res_valid,
    input  logic           res_stall,
    output kts_pkg::res_t  res
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          rvld_reg, rvld_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic          found_reg, found_next;
    logic          have_prev_reg, have_prev_next;
    logic signed [kts_pkg::KEY_W-1:0] best_key_reg, best_key_next;
    logic [kts_pkg::TAG_W-1:0]        best_tag_reg, best_tag_next;
    logic [AW-1:0]                    best_idx_reg, best_idx_next;
    logic signed [kts_pkg::KEY_W-1:0] prev_key_reg, prev_key_next;
    logic [AW-1:0]                    prev_idx_reg, prev_idx_next;

    logic                             wr_en;
    logic signed [kts_pkg::KEY_W-1:0] rd_key;
    logic [kts_pkg::TAG_W-1:0]        rd_tag;
    logic                             accept;
    logic                             after_prev;
    logic                             below_best;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_LOAD);
    assign wr_en      = accept && (fill_reg < FULL);

    kts_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_key  (item.key),
        .wr_tag  (item.tag),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_key  (rd_key),
        .rd_tag  (rd_tag)
    );

    // Candidate order is (key, arrival index), which keeps equal keys stable.
    assign after_prev = !have_prev_reg || (rd_key > prev_key_reg) ||
                        ((rd_key == prev_key_reg) && (ridx_reg > prev_idx_reg));
    assign below_best = !found_reg || (rd_key < best_key_reg) ||
                        ((rd_key == best_key_reg) && (ridx_reg < best_idx_reg));

    // Result word comes straight from the held selection.
    assign res_valid    = (state_reg == ST_EMIT);
    assign res.key_res  = best_key_reg;
    assign res.tag_res  = best_tag_reg;
    assign res.last_res = (emit_reg == fill_reg - CW'(1));
    assign res.overflow = ovf_reg;

    // Control sequence: load, then one scan and one emit per result.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        scan_next      = scan_reg;
        rvld_next      = 1'b0;
        ridx_next      = scan_reg[AW-1:0];
        emit_next      = emit_reg;
        found_next     = found_reg;
        have_prev_next = have_prev_reg;
        best_key_next  = best_key_reg;
        best_tag_next  = best_tag_reg;
        best_idx_next  = best_idx_reg;
        prev_key_next  = prev_key_reg;
        prev_idx_next  = prev_idx_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (wr_en)
                        fill_next = fill_reg + CW'(1);
                    else
                        ovf_next = 1'b1;
                    if (item.last)
                    begin
                        state_next     = ST_SCAN;
                        scan_next      = '0;
                        found_next     = 1'b0;
                        have_prev_next = 1'b0;
                        emit_next      = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_reg < fill_reg)
                begin
                    scan_next = scan_reg + CW'(1);
                    rvld_next = 1'b1;
                end
                if (rvld_reg && after_prev && below_best)
                begin
                    found_next    = 1'b1;
                    best_key_next = rd_key;
                    best_tag_next = rd_tag;
                    best_idx_next = ridx_reg;
                end
                if ((scan_reg == fill_reg) && !rvld_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!res_stall)
                begin
                    if (res.last_res)
                    begin
                        state_next = ST_LOAD;
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next     = ST_SCAN;
                        scan_next      = '0;
                        found_next     = 1'b0;
                        have_prev_next = 1'b1;
                        prev_key_next  = best_key_reg;
                        prev_idx_next  = best_idx_reg;
                        emit_next      = emit_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            scan_reg      <= '0;
            rvld_reg      <= 1'b0;
            emit_reg      <= '0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            scan_reg      <= scan_next;
            rvld_reg      <= rvld_next;
            emit_reg      <= emit_next;
            found_reg     <= found_next;
            have_prev_reg <= have_prev_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ridx_reg     <= ridx_next;
        best_key_reg <= best_key_next;
        best_tag_reg <= best_tag_next;
        best_idx_reg <= best_idx_next;
        prev_key_reg <= prev_key_next;
        prev_idx_reg <= prev_idx_next;
    end

endmodule

// File: rtl/kts_mem.sv
// ----------------------------------------------------------------------------
// kts_mem
// Key and tag store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kts_mem #(
    parameter int DEPTH = kts_pkg::MAX_ITEMS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic signed [kts_pkg::KEY_W-1:0] wr_key,
    input  logic [kts_pkg::TAG_W-1:0]      wr_tag,
    input  logic [AW-1:0]                  rd_addr,
    output logic signed [kts_pkg::KEY_W-1:0] rd_key,
    output logic [kts_pkg::TAG_W-1:0]      rd_tag
);

    logic [kts_pkg::KEY_W-1:0] key_mem [DEPTH];
    logic [kts_pkg::TAG_W-1:0] tag_mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            tag_mem[wr_addr] <= wr_tag;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[rd_addr];
        rd_tag <= tag_mem[rd_addr];
    end

endmodule

// File: rtl/kts_checker.sv
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks of the key/tag sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_tag_sorter_top_assert.svh"

module kts_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_valid,
    input logic           item_stall,
    input kts_pkg::item_t item,
    input logic           res_valid,
    input logic           res_stall,
    input kts_pkg::res_t  res
);

    // A stalled result word holds.
    `KTS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result changed under stall")
    // No item is taken while results are pending.
    `KTS_ASSERT_HOLD(a_no_load_in_drain, !res_valid || item_stall, "item taken during drain")
    // The next result of a set needs a new scan, so valid drops after a handoff.
    `KTS_ASSERT_NEXT(a_gap_after_res, res_valid && !res_stall, !res_valid, "result without rescan")
    // An accepted final item always moves the block out of loading.
    `KTS_ASSERT_NEXT(a_last_starts_sort, item_valid && !item_stall && item.last, item_stall, "sort did not start")

endmodule

bind key_tag_sorter_top kts_checker u_kts_checker (.*);
